### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the engine top level
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ibst_pkg.sv
// ----------------------------------------------------------------------------
// ibst_pkg
// Shared constants, codes and types of the implicit-array search tree engine
// ----------------------------------------------------------------------------
package ibst_pkg;

    // default geometry
    localparam int LEVELS_DEF   = 6;
    localparam int KEY_BITS_DEF = 16;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    // result flags from the core to the output stage
    typedef struct packed {
        logic [1:0] status;
        logic       tree_empty;
    } res_info_t;

endpackage

### design/ibst_core.sv
// ----------------------------------------------------------------------------
// ibst_core
// Sequencer and slot memory: each slot holds a valid bit and a key, children
// of slot i at 2i+1 and 2i+2; walks the tree one memory read per step
// ----------------------------------------------------------------------------
module ibst_core
    import ibst_pkg::*;
#(
    parameter int LEVELS   = LEVELS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start_valid,
    output logic                       start_ready,
    input  logic [1:0]                 start_cmd,
    input  logic signed [KEY_BITS-1:0] start_key,
    output logic                       res_valid,
    input  logic                       res_ready,
    output res_info_t                  res_info,
    output logic signed [KEY_BITS-1:0] res_min,
    output logic signed [KEY_BITS-1:0] res_max
);

    localparam int NSLOTS  = (1 << LEVELS) - 1;
    localparam int IDX_W   = LEVELS + 1;
    localparam int ADDR_W  = LEVELS;
    localparam int ENTRY_W = KEY_BITS + 1;

    localparam logic [IDX_W-1:0]  NSLOTS_IDX = IDX_W'(NSLOTS);
    localparam logic [IDX_W-1:0]  IDX_ZERO   = IDX_W'(0);
    localparam logic [IDX_W-1:0]  IDX_ONE    = IDX_W'(1);
    localparam logic [IDX_W-1:0]  IDX_TWO    = IDX_W'(2);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NSLOTS - 1);

    // sequencer states
    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_INS_RD  = 5'd2;
    localparam logic [4:0] S_INS_CHK = 5'd3;
    localparam logic [4:0] S_DEL_RD  = 5'd4;
    localparam logic [4:0] S_DEL_CHK = 5'd5;
    localparam logic [4:0] S_RMR_RD  = 5'd6;
    localparam logic [4:0] S_RMR_CHK = 5'd7;
    localparam logic [4:0] S_RML_RD  = 5'd8;
    localparam logic [4:0] S_RML_CHK = 5'd9;
    localparam logic [4:0] S_GL_RD   = 5'd10;
    localparam logic [4:0] S_GL_CHK  = 5'd11;
    localparam logic [4:0] S_GR_RD   = 5'd12;
    localparam logic [4:0] S_GR_CHK  = 5'd13;
    localparam logic [4:0] S_MOVE    = 5'd14;
    localparam logic [4:0] S_MM_RD   = 5'd15;
    localparam logic [4:0] S_MM_CHK  = 5'd16;
    localparam logic [4:0] S_MN_RD   = 5'd17;
    localparam logic [4:0] S_MN_CHK  = 5'd18;
    localparam logic [4:0] S_MX_RD   = 5'd19;
    localparam logic [4:0] S_MX_CHK  = 5'd20;
    localparam logic [4:0] S_DONE    = 5'd21;

    // child slot index of p
    function automatic logic [IDX_W-1:0] child(input logic [IDX_W-1:0] p, input logic right);
        logic [IDX_W-1:0] base;
        base = {p[IDX_W-2:0], 1'b0};
        return base + (right ? IDX_TWO : IDX_ONE);
    endfunction

    // slot memory
    logic [ENTRY_W-1:0] mem [NSLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // control registers
    logic [4:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0]  prb_reg, prb_next;
    logic              hit_reg, hit_next;

    // payload registers
    logic [1:0]                 cmd_reg, cmd_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           vac_reg, vac_next;
    logic signed [KEY_BITS-1:0] skey_reg, skey_next;
    logic [1:0]                 status_reg, status_next;
    logic                       empty_reg, empty_next;
    logic signed [KEY_BITS-1:0] min_reg, min_next;
    logic signed [KEY_BITS-1:0] max_reg, max_next;

    // probe issue and read-back decode
    logic                       do_probe;
    logic [IDX_W-1:0]           probe;
    logic                       probe_in;
    logic                       occ;
    logic signed [KEY_BITS-1:0] rkey;
    logic                       go_right;

    assign probe_in = probe < NSLOTS_IDX;
    assign rd_en    = do_probe && probe_in;
    assign rd_addr  = probe[ADDR_W-1:0];
    assign occ      = hit_reg && rd_data_reg[KEY_BITS];
    assign rkey     = rd_data_reg[KEY_BITS-1:0];
    assign go_right = key_reg > rkey;

    // memory port, one access per cycle by construction of the sequence
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // next-state logic
    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        vac_next    = vac_reg;
        skey_next   = skey_reg;
        status_next = status_reg;
        empty_next  = empty_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        do_probe    = 1'b0;
        probe       = prb_reg;
        wr_en       = 1'b0;
        wr_addr     = clr_reg;
        wr_data     = '0;

        case (state_reg)
            // clearing pass after reset
            S_CLR: begin
                wr_en    = 1'b1;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start_valid) begin
                    cmd_next    = start_cmd;
                    key_next    = start_key;
                    idx_next    = IDX_ZERO;
                    status_next = STAT_OK;
                    case (start_cmd)
                        CMD_INSERT: state_next = S_INS_RD;
                        CMD_DELETE: state_next = S_DEL_RD;
                        default:    state_next = S_MM_RD;
                    endcase
                end
            end
            // insert descent
            S_INS_RD: begin
                do_probe   = 1'b1;
                probe      = idx_reg;
                state_next = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (!hit_reg) begin
                    status_next = STAT_FULL;
                    state_next  = S_MM_RD;
                end else if (!occ) begin
                    wr_en      = 1'b1;
                    wr_addr    = prb_reg[ADDR_W-1:0];
                    wr_data    = {1'b1, key_reg};
                    state_next = S_MM_RD;
                end else begin
                    idx_next   = child(prb_reg, go_right);
                    state_next = S_INS_RD;
                end
            end
            // delete search
            S_DEL_RD: begin
                do_probe   = 1'b1;
                probe      = idx_reg;
                state_next = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (!occ) begin
                    status_next = (prb_reg == IDX_ZERO) ? STAT_EMPTY : STAT_NOT_FOUND;
                    state_next  = S_MM_RD;
                end else if (rkey == key_reg) begin
                    vac_next   = prb_reg;
                    state_next = S_RMR_RD;
                end else begin
                    idx_next   = child(prb_reg, go_right);
                    state_next = S_DEL_RD;
                end
            end
            // removal at the vacated slot: right child first
            S_RMR_RD: begin
                do_probe   = 1'b1;
                probe      = child(vac_reg, 1'b1);
                state_next = S_RMR_CHK;
            end
            S_RMR_CHK: begin
                if (occ) begin
                    idx_next   = prb_reg;
                    skey_next  = rkey;
                    state_next = S_GL_RD;
                end else begin
                    state_next = S_RML_RD;
                end
            end
            S_RML_RD: begin
                do_probe   = 1'b1;
                probe      = child(vac_reg, 1'b0);
                state_next = S_RML_CHK;
            end
            S_RML_CHK: begin
                if (occ) begin
                    idx_next   = prb_reg;
                    skey_next  = rkey;
                    state_next = S_GR_RD;
                end else begin
                    // leaf: free it
                    wr_en      = 1'b1;
                    wr_addr    = vac_reg[ADDR_W-1:0];
                    wr_data    = '0;
                    state_next = S_MM_RD;
                end
            end
            // successor: leftmost of the right subtree
            S_GL_RD: begin
                do_probe   = 1'b1;
                probe      = child(idx_reg, 1'b0);
                state_next = S_GL_CHK;
            end
            S_GL_CHK: begin
                if (occ) begin
                    idx_next   = prb_reg;
                    skey_next  = rkey;
                    state_next = S_GL_RD;
                end else begin
                    state_next = S_MOVE;
                end
            end
            // predecessor: rightmost of the left subtree
            S_GR_RD: begin
                do_probe   = 1'b1;
                probe      = child(idx_reg, 1'b1);
                state_next = S_GR_CHK;
            end
            S_GR_CHK: begin
                if (occ) begin
                    idx_next   = prb_reg;
                    skey_next  = rkey;
                    state_next = S_GR_RD;
                end else begin
                    state_next = S_MOVE;
                end
            end
            // move the chosen key up and repeat at its old slot
            S_MOVE: begin
                wr_en      = 1'b1;
                wr_addr    = vac_reg[ADDR_W-1:0];
                wr_data    = {1'b1, skey_reg};
                vac_next   = idx_reg;
                state_next = S_RMR_RD;
            end
            // root read for min and max
            S_MM_RD: begin
                do_probe   = 1'b1;
                probe      = IDX_ZERO;
                state_next = S_MM_CHK;
            end
            S_MM_CHK: begin
                idx_next = IDX_ZERO;
                if (!occ) begin
                    empty_next = 1'b1;
                    min_next   = '0;
                    max_next   = '0;
                    state_next = S_DONE;
                end else begin
                    empty_next = 1'b0;
                    min_next   = rkey;
                    max_next   = rkey;
                    state_next = S_MN_RD;
                end
            end
            // minimum: leftmost slot
            S_MN_RD: begin
                do_probe   = 1'b1;
                probe      = child(idx_reg, 1'b0);
                state_next = S_MN_CHK;
            end
            S_MN_CHK: begin
                if (occ) begin
                    min_next   = rkey;
                    idx_next   = prb_reg;
                    state_next = S_MN_RD;
                end else begin
                    idx_next   = IDX_ZERO;
                    state_next = S_MX_RD;
                end
            end
            // maximum: rightmost slot
            S_MX_RD: begin
                do_probe   = 1'b1;
                probe      = child(idx_reg, 1'b1);
                state_next = S_MX_CHK;
            end
            S_MX_CHK: begin
                if (occ) begin
                    max_next   = rkey;
                    idx_next   = prb_reg;
                    state_next = S_MX_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign prb_next = do_probe ? probe : prb_reg;
    assign hit_next = do_probe ? probe_in : hit_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            prb_reg   <= '0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            prb_reg   <= prb_next;
            hit_reg   <= hit_next;
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        vac_reg    <= vac_next;
        skey_reg   <= skey_next;
        status_reg <= status_next;
        empty_reg  <= empty_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
    end

    // insert and delete report their own status, query and unused report emptiness
    assign start_ready         = state_reg == S_IDLE;
    assign res_valid           = state_reg == S_DONE;
    assign res_info.status     = (cmd_reg == CMD_INSERT || cmd_reg == CMD_DELETE) ?
                                 status_reg : (empty_reg ? STAT_EMPTY : STAT_OK);
    assign res_info.tree_empty = empty_reg;
    assign res_min             = min_reg;
    assign res_max             = max_reg;

endmodule

### design/implicit_array_bst_engine.sv
// ----------------------------------------------------------------------------
// implicit_array_bst_engine
// Binary search tree in an implicit slot array: insert, delete or query one
// key per transfer, report status, emptiness, minimum and maximum
// ----------------------------------------------------------------------------
//  channel  | ports                                    | direction
//  ---------+------------------------------------------+----------
//  input    | s_valid s_ready s_cmd s_key              | in
//  result   | m_valid m_ready m_status m_tree_empty    | out
//           | m_min_key m_max_key                      |
//
//  One item at a time; each memory step is a read state and a check state;
//  an item is accepted in S_IDLE and its result is handed over from S_DONE.
//  Insert or delete first searches from the root; delete then moves successor or
//  predecessor keys up until a leaf slot is freed; a min/max walk ends each item.
//  After reset a clearing pass writes all 2^LEVELS-1 slots; s_ready stays low.
//  A result waits in the output register; the core stalls only while it is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module implicit_array_bst_engine
    import ibst_pkg::*;
#(
    parameter int LEVELS   = LEVELS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic signed [KEY_BITS-1:0] s_key,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic                       m_tree_empty,
    output logic signed [KEY_BITS-1:0] m_min_key,
    output logic signed [KEY_BITS-1:0] m_max_key
);

    logic                       core_res_valid;
    logic                       core_res_ready;
    res_info_t                  core_info;
    logic signed [KEY_BITS-1:0] core_min;
    logic signed [KEY_BITS-1:0] core_max;

    logic                       m_valid_reg, m_valid_next;
    res_info_t                  info_reg;
    logic signed [KEY_BITS-1:0] min_reg;
    logic signed [KEY_BITS-1:0] max_reg;
    logic                       out_load;

    ibst_core #(
        .LEVELS   (LEVELS),
        .KEY_BITS (KEY_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_valid (s_valid),
        .start_ready (s_ready),
        .start_cmd   (s_cmd),
        .start_key   (s_key),
        .res_valid   (core_res_valid),
        .res_ready   (core_res_ready),
        .res_info    (core_info),
        .res_min     (core_min),
        .res_max     (core_max)
    );

    // output register: loads when empty or when its transfer completes
    assign core_res_ready = !m_valid_reg || m_ready;
    assign out_load       = core_res_valid && core_res_ready;
    assign m_valid_next   = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            info_reg <= core_info;
            min_reg  <= core_min;
            max_reg  <= core_max;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = info_reg.status;
    assign m_tree_empty = info_reg.tree_empty;
    assign m_min_key    = min_reg;
    assign m_max_key    = max_reg;

    // checks
    `ASSERT_SAME(a_no_start_while_done, aclk, aresetn, core_res_valid, !s_ready, "input taken while a result is pending")
    `ASSERT_NEXT(a_busy_after_start, aclk, aresetn, s_valid && s_ready, !s_ready, "ready stayed high after an input transfer")
    `ASSERT_SAME(a_empty_keys_zero, aclk, aresetn, m_valid && m_tree_empty, m_min_key == '0 && m_max_key == '0, "empty tree with nonzero min or max")
    `ASSERT_SAME(a_empty_status, aclk, aresetn, m_valid && m_status == STAT_EMPTY, m_tree_empty, "empty status on a nonempty tree")
    `ASSERT_SAME(a_full_nonempty, aclk, aresetn, m_valid && m_status == STAT_FULL, !m_tree_empty, "full status on an empty tree")

endmodule
